>>> design/ntc_thermistor_linearizer_unit_assert.svh
// assertion macros for the thermistor linearizer checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef NTC_THERMISTOR_LINEARIZER_UNIT_ASSERT_SVH
`define NTC_THERMISTOR_LINEARIZER_UNIT_ASSERT_SVH

// clocked check, switched off while reset is applied
`define NTCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds while reset is applied
`define NTCL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/ntcl_pkg.sv
// shared types, widths and the resistance/temperature table of the linearizer
// no dependencies
package ntcl_pkg;

  localparam int ADC_W   = 12;
  localparam int SER_W   = 17;
  localparam int TEMP_W  = 12;
  localparam int STAT_W  = 2;
  localparam int OHM_W   = 23;
  localparam int TDIFF_W = 7;   // widest temperature step between neighbors is 50
  localparam int TBL_ENTRIES = 43;
  localparam int ADDR_W  = $clog2(TBL_ENTRIES);
  localparam int DIV_N_W = 30;
  localparam int DIV_D_W = OHM_W;

  localparam logic [SER_W-1:0] SERIES_RESET = SER_W'(10000);

  localparam logic [STAT_W-1:0] RS_IN_RANGE = 2'd0;
  localparam logic [STAT_W-1:0] RS_COLD     = 2'd1;
  localparam logic [STAT_W-1:0] RS_HOT      = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(TBL_ENTRIES - 1);

  localparam logic [OHM_W-1:0] TBL_OHMS [TBL_ENTRIES] = '{
    23'd4879070, 23'd3464229, 23'd2477981, 23'd1785436, 23'd1295555, 23'd946674,
    23'd695647, 23'd515872, 23'd384196, 23'd288612, 23'd217755, 23'd165642,
    23'd126876, 23'd97905, 23'd76088, 23'd59530, 23'd47000, 23'd36824,
    23'd29314, 23'd23470, 23'd18902, 23'd15301, 23'd12408, 23'd10117,
    23'd8315, 23'd6869, 23'd5685, 23'd4724, 23'd3936, 23'd3291, 23'd2765,
    23'd2339, 23'd1980, 23'd1682, 23'd1433, 23'd1225, 23'd1049, 23'd901,
    23'd776, 23'd669, 23'd581, 23'd505, 23'd441
  };

  localparam logic signed [TEMP_W-1:0] TBL_TENTHS [TBL_ENTRIES] = '{
    -12'sd550, -12'sd500, -12'sd450, -12'sd400, -12'sd350, -12'sd300,
    -12'sd250, -12'sd200, -12'sd150, -12'sd100, -12'sd50, 12'sd0,
    12'sd50, 12'sd100, 12'sd150, 12'sd200, 12'sd250, 12'sd300, 12'sd350,
    12'sd400, 12'sd450, 12'sd500, 12'sd550, 12'sd600, 12'sd650, 12'sd700,
    12'sd750, 12'sd800, 12'sd850, 12'sd900, 12'sd950, 12'sd1000, 12'sd1050,
    12'sd1100, 12'sd1150, 12'sd1200, 12'sd1250, 12'sd1300, 12'sd1350,
    12'sd1400, 12'sd1450, 12'sd1500, 12'sd1550
  };

  localparam logic signed [TEMP_W-1:0] TEMP_COLD = TBL_TENTHS[0];
  localparam logic signed [TEMP_W-1:0] TEMP_HOT  = TBL_TENTHS[TBL_ENTRIES-1];

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/ntc_thermistor_linearizer_unit.sv
// top level of the ntc thermistor linearizer
// depends on ntcl_pkg and ntcl_div
//
// usage:
//   an item (one 12-bit converter code on adc_code_i) is taken at a rising edge
//   with start high and busy low. busy stays high until the item is finished.
//   the result (temperature_tenths_o, range_status_o) is shown for exactly one
//   cycle with valid_o high, the first cycle with busy low again; there is no
//   backpressure, and a new item may be started in that same cycle.
//   cfg_we_i/cfg_wdata_i write the series resistance in ohms; write only while
//   busy is low.
// result paths, from the accepting edge to valid_o:
//   a code at or above full scale: a cold clamp without division, busy never rises.
//   clamped results: set by the 30-step resistance divider.
//   in-range results: set by two passes through the shared divider and the
//   table scan over rows 1..42, one synchronous rom read per cycle.
// reset:
//   asynchronous, active low; returns to idle, drops valid_o, and loads the
//   series resistance with 10000 ohms.
module ntc_thermistor_linearizer_unit #(
  parameter int ADC_FULL_SCALE = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ntcl_pkg::ADC_W-1:0]           adc_code_i,
  input  logic                                 cfg_we_i,
  input  logic [ntcl_pkg::SER_W-1:0]           cfg_wdata_i,
  output logic                                 valid_o,
  output logic signed [ntcl_pkg::TEMP_W-1:0]   temperature_tenths_o,
  output logic [ntcl_pkg::STAT_W-1:0]          range_status_o
);
  import ntcl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV_R = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MUL   = 5'b01000,
    S_DIV_T = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SER_W-1:0]         series_q;
  logic [DIV_N_W-1:0]       ohms_q, ohms_d;
  logic [ADDR_W-1:0]        addr_q, addr_d;
  logic [OHM_W-1:0]         rom_ohms_q;
  logic signed [TEMP_W-1:0] rom_t_q;
  logic [OHM_W-1:0]         prev_ohms_q, prev_ohms_d;
  logic signed [TEMP_W-1:0] prev_t_q, prev_t_d;
  logic [OHM_W-1:0]         diff_q, diff_d;
  logic [OHM_W-1:0]         den_q, den_d;
  logic [TDIFF_W-1:0]       dt_q, dt_d;
  logic signed [TEMP_W-1:0] base_t_q, base_t_d;

  logic                     valid_q, valid_d;
  logic signed [TEMP_W-1:0] temp_q, temp_d;
  logic [STAT_W-1:0]        status_q, status_d;

  logic     accept;
  logic     code_over;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept    = start && (state_q == S_IDLE);
  assign code_over = 32'(adc_code_i) >= 32'(ADC_FULL_SCALE);

  ntcl_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    div_req = '0;
    if (accept && !code_over) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_N_W'(adc_code_i) * DIV_N_W'(series_q);
      div_req.divisor  = DIV_D_W'(32'(ADC_FULL_SCALE) - 32'(adc_code_i));
    end else if (state_q == S_MUL) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_N_W'(dt_q) * DIV_N_W'(diff_q);
      div_req.divisor  = den_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    ohms_d      = ohms_q;
    addr_d      = addr_q;
    prev_ohms_d = prev_ohms_q;
    prev_t_d    = prev_t_q;
    diff_d      = diff_q;
    den_d       = den_q;
    dt_d        = dt_q;
    base_t_d    = base_t_q;
    valid_d     = 1'b0;
    temp_d      = temp_q;
    status_d    = status_q;
    unique case (state_q)
      S_IDLE: begin
        addr_d = '0;
        if (accept) begin
          if (code_over) begin
            valid_d  = 1'b1;
            temp_d   = TEMP_COLD;
            status_d = RS_COLD;
          end else begin
            state_d = S_DIV_R;
          end
        end
      end
      S_DIV_R: begin
        if (div_rsp.done) begin
          ohms_d = div_rsp.quotient;
          if (div_rsp.quotient > DIV_N_W'(TBL_OHMS[0])) begin
            valid_d  = 1'b1;
            temp_d   = TEMP_COLD;
            status_d = RS_COLD;
            state_d  = S_IDLE;
          end else if (div_rsp.quotient <= DIV_N_W'(TBL_OHMS[TBL_ENTRIES-1])) begin
            valid_d  = 1'b1;
            temp_d   = TEMP_HOT;
            status_d = RS_HOT;
            state_d  = S_IDLE;
          end else begin
            // rom shows row 0 while idle and dividing
            prev_ohms_d = rom_ohms_q;
            prev_t_d    = rom_t_q;
            addr_d      = ADDR_W'(1);
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ohms_q > DIV_N_W'(rom_ohms_q) || addr_q == ADDR_LAST) begin
          diff_d   = prev_ohms_q - OHM_W'(ohms_q);
          den_d    = prev_ohms_q - rom_ohms_q;
          dt_d     = TDIFF_W'(rom_t_q - prev_t_q);
          base_t_d = prev_t_q;
          state_d  = S_MUL;
        end else begin
          prev_ohms_d = rom_ohms_q;
          prev_t_d    = rom_t_q;
          addr_d      = addr_q + ADDR_W'(1);
        end
      end
      S_MUL: begin
        state_d = S_DIV_T;
      end
      S_DIV_T: begin
        if (div_rsp.done) begin
          valid_d  = 1'b1;
          temp_d   = base_t_q + TEMP_W'(div_rsp.quotient);
          status_d = RS_IN_RANGE;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      series_q <= SERIES_RESET;
      addr_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        series_q <= cfg_wdata_i;
      end
    end
  end

  // table rom, read address is the next row so the data lines up with addr_q
  always_ff @(posedge clk_i) begin
    rom_ohms_q <= TBL_OHMS[addr_d];
    rom_t_q    <= TBL_TENTHS[addr_d];
  end

  always_ff @(posedge clk_i) begin
    ohms_q      <= ohms_d;
    prev_ohms_q <= prev_ohms_d;
    prev_t_q    <= prev_t_d;
    diff_q      <= diff_d;
    den_q       <= den_d;
    dt_q        <= dt_d;
    base_t_q    <= base_t_d;
    temp_q      <= temp_d;
    status_q    <= status_d;
  end

  assign busy                 = (state_q != S_IDLE);
  assign valid_o              = valid_q;
  assign temperature_tenths_o = temp_q;
  assign range_status_o       = status_q;

endmodule

>>> design/ntcl_div.sv
// unsigned restoring divider, one quotient bit per cycle
// depends on ntcl_pkg for the request and response structs
module ntcl_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ntcl_pkg::div_req_t req_i,
  output ntcl_pkg::div_rsp_t rsp_o
);
  import ntcl_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIV_N_W-1:0] quo_q, quo_d;
  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [DIV_D_W-1:0] dvs_q, dvs_d;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  assign rem_sh = {rem_q, quo_q[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(DIV_N_W);
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_d = fits ? DIV_D_W'(rem_sh - {1'b0, dvs_q}) : DIV_D_W'(rem_sh);
      quo_d = {quo_q[DIV_N_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> design/ntcl_checker.sv
// port-level checks for the thermistor linearizer, bound to the top level
// depends on ntcl_pkg and ntc_thermistor_linearizer_unit_assert.svh
`include "ntc_thermistor_linearizer_unit_assert.svh"

module ntcl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               valid_o,
  input logic signed [ntcl_pkg::TEMP_W-1:0] temperature_tenths_o,
  input logic [ntcl_pkg::STAT_W-1:0]        range_status_o
);
  import ntcl_pkg::*;

  // an item either finishes at once or keeps the block busy
  `NTCL_ASSERT(a_accept_progress, start && !busy |=> busy || valid_o, "item accepted but dropped")

  `NTCL_ASSERT(a_result_idle, valid_o |-> !busy, "result shown while still busy")

  `NTCL_ASSERT(a_cold_value, valid_o && range_status_o == RS_COLD |-> temperature_tenths_o == TEMP_COLD, "cold clamp value wrong")

  `NTCL_ASSERT(a_hot_value, valid_o && range_status_o == RS_HOT |-> temperature_tenths_o == TEMP_HOT, "hot clamp value wrong")

  `NTCL_ASSERT_RST(a_reset_quiet, !rst_ni |-> !valid_o && !busy, "activity during reset")

endmodule

bind ntc_thermistor_linearizer_unit ntcl_checker u_ntcl_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .start               (start),
  .busy                (busy),
  .valid_o             (valid_o),
  .temperature_tenths_o(temperature_tenths_o),
  .range_status_o      (range_status_o)
);
